// ----- rtl/lmd_pkg.sv -----
// Shared constants and types of the 3x3 local maximum detector.
// Used by every module in rtl/; depends on nothing else.
package lmd_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_BITS_DEF = 16;
  localparam int MAX_HEIGHT     = 4096;

  localparam int ROW_W      = 12;
  localparam int OUT_COL_W  = 10;
  localparam int IMG_W_BITS = 11;
  localparam int IMG_H_BITS = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int NUM_CAND = 4;
  localparam int CAND_UL  = 0;
  localparam int CAND_UR  = 1;
  localparam int CAND_LL  = 2;
  localparam int CAND_LR  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_BORDER_MODE  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic full;
    logic r1;
    logic r2;
    logic rlast;
    logic c1;
    logic c2;
    logic clast;
  } pos_flags_t;

endpackage

// ----- rtl/lmd_line_mem.sv -----
// Line buffer memory holding the two previous rows, one entry per column.
// Synchronous write, registered read; uses lmd_pkg.
module lmd_line_mem #(
  parameter int DEPTH = lmd_pkg::MAX_WIDTH_DEF,
  parameter int DW    = 2 * lmd_pkg::PIXEL_BITS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);
  import lmd_pkg::*;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/lmd_peak_eval.sv -----
// 3x3 window registers and the strict maximum tests of the four candidates.
// Uses lmd_pkg for the position flags and candidate numbering.
module lmd_peak_eval #(
  parameter int PB = lmd_pkg::PIXEL_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        shift_i,
  input  logic signed [PB-1:0]        top_i,
  input  logic signed [PB-1:0]        mid_i,
  input  logic signed [PB-1:0]        bot_i,
  input  lmd_pkg::pos_flags_t         flags_i,
  output logic [lmd_pkg::NUM_CAND-1:0] mask_o,
  output logic signed [PB-1:0]        value_o [lmd_pkg::NUM_CAND]
);
  import lmd_pkg::*;

  localparam int CAND_R [NUM_CAND] = '{1, 1, 2, 2};
  localparam int CAND_C [NUM_CAND] = '{1, 2, 1, 2};

  logic signed [PB-1:0] win_q [3][3];
  logic signed [PB-1:0] win_d [3][3];
  logic signed [PB-1:0] pad   [4][4];
  logic [NUM_CAND-1:0]  en, up, dn, lf, rt, ok;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
    end
    win_d[0][2] = top_i;
    win_d[1][2] = mid_i;
    win_d[2][2] = bot_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (shift_i) begin
      win_q <= win_d;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        pad[r][c] = '0;
      end
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        pad[r][c] = win_d[r][c];
      end
    end
  end

  always_comb begin
    en[CAND_UL] = flags_i.r1 & flags_i.c1;
    up[CAND_UL] = flags_i.r2;
    dn[CAND_UL] = 1'b1;
    lf[CAND_UL] = flags_i.c2;
    rt[CAND_UL] = 1'b1;
    en[CAND_UR] = flags_i.r1 & flags_i.clast;
    up[CAND_UR] = flags_i.r2;
    dn[CAND_UR] = 1'b1;
    lf[CAND_UR] = flags_i.c1;
    rt[CAND_UR] = 1'b0;
    en[CAND_LL] = flags_i.rlast & flags_i.c1;
    up[CAND_LL] = flags_i.r1;
    dn[CAND_LL] = 1'b0;
    lf[CAND_LL] = flags_i.c2;
    rt[CAND_LL] = 1'b1;
    en[CAND_LR] = flags_i.rlast & flags_i.clast;
    up[CAND_LR] = flags_i.r1;
    dn[CAND_LR] = 1'b0;
    lf[CAND_LR] = flags_i.c1;
    rt[CAND_LR] = 1'b0;
  end

  always_comb begin
    for (int k = 0; k < NUM_CAND; k++) begin
      ok[k] = 1'b1;
      for (int dy = 0; dy < 3; dy++) begin
        for (int dx = 0; dx < 3; dx++) begin
          if (!(dy == 1 && dx == 1) &&
              (dy == 0 ? up[k] : (dy == 2 ? dn[k] : 1'b1)) &&
              (dx == 0 ? lf[k] : (dx == 2 ? rt[k] : 1'b1))) begin
            if (!(pad[CAND_R[k] + dy - 1][CAND_C[k] + dx - 1] <
                  pad[CAND_R[k]][CAND_C[k]])) begin
              ok[k] = 1'b0;
            end
          end
        end
      end
      mask_o[k]  = en[k] & ok[k] &
                   (!flags_i.full | (up[k] & dn[k] & lf[k] & rt[k]));
      value_o[k] = pad[CAND_R[k]][CAND_C[k]];
    end
  end

endmodule

// ----- rtl/lmd_out_seq.sv -----
// Result register holding the verdicts of one pixel; sends its reports in
// raster order, one word per cycle while out_ready_i is high; uses lmd_pkg.
module lmd_out_seq #(
  parameter int PB    = lmd_pkg::PIXEL_BITS_DEF,
  parameter int COL_W = $clog2(lmd_pkg::MAX_WIDTH_DEF)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic [lmd_pkg::NUM_CAND-1:0]  mask_i,
  input  logic signed [PB-1:0]          value_i [lmd_pkg::NUM_CAND],
  input  logic [lmd_pkg::ROW_W-1:0]     row_i,
  input  logic [COL_W-1:0]              col_i,
  output logic                          ready_o,
  output logic                          valid_o,
  input  logic                          out_ready_i,
  output logic [lmd_pkg::ROW_W-1:0]     peak_row_o,
  output logic [lmd_pkg::OUT_COL_W-1:0] peak_col_o,
  output logic signed [PB-1:0]          peak_value_o,
  output logic                          last_o
);
  import lmd_pkg::*;

  logic [NUM_CAND-1:0] pend_q, pend_d, sel, rest;
  logic signed [PB-1:0] val_q [NUM_CAND];
  logic [ROW_W-1:0]    row_q;
  logic [COL_W-1:0]    col_q;
  logic [COL_W-1:0]    col_sel;

  assign sel     = pend_q & (~pend_q + NUM_CAND'(1));
  assign rest    = pend_q & ~sel;
  assign valid_o = |pend_q;
  assign last_o  = (rest == '0);
  assign ready_o = !valid_o || (last_o && out_ready_i);

  always_comb begin
    pend_d = pend_q;
    if (load_i) begin
      pend_d = mask_i;
    end else if (valid_o && out_ready_i) begin
      pend_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      val_q <= value_i;
      row_q <= row_i;
      col_q <= col_i;
    end
  end

  always_comb begin
    peak_value_o = val_q[CAND_UL];
    for (int k = 0; k < NUM_CAND; k++) begin
      if (sel[k]) begin
        peak_value_o = val_q[k];
      end
    end
    peak_row_o = (sel[CAND_LL] | sel[CAND_LR]) ? row_q : row_q - ROW_W'(1);
    col_sel    = (sel[CAND_UR] | sel[CAND_LR]) ? col_q : col_q - COL_W'(1);
    peak_col_o = OUT_COL_W'(col_sel);
  end

endmodule

// ----- rtl/local_maximum_3x3_detector.sv -----
// Top level of the 3x3 strict local maximum detector over a pixel stream.
// Instantiates lmd_line_mem, lmd_peak_eval and lmd_out_seq; uses lmd_pkg.
//
//   channel  direction  handshake            payload
//   s_axis   in         tvalid/tready        tdata: pixel
//   m_axis   out        tvalid/tready        tdata: peak_row, peak_col, peak_value; tlast: last
//   cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data (ready is always high)
//
// One pixel is accepted per cycle unless the report path stalls the input. A pixel that
// ends a row, or any pixel of the last row, releases up to two reports and the last
// pixel of a frame up to four; the single report port sends one word per cycle while
// the receiver is ready, and the input stalls until the last of them is being sent.
// After its releasing pixel is accepted, a report passes the line memory read and
// compare stage, then the result register. Reset clears the counters, pipeline valids
// and registers; the line memory is not cleared and needs no clearing pass. Stalls on
// the output back up through the result register into the input ready.
module local_maximum_3x3_detector #(
  parameter int MAX_WIDTH  = lmd_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = lmd_pkg::PIXEL_BITS_DEF,
  localparam int S_W = ((PIXEL_BITS + 7) / 8) * 8,
  localparam int M_W = ((lmd_pkg::ROW_W + lmd_pkg::OUT_COL_W + PIXEL_BITS + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [S_W-1:0]                  s_axis_tdata,  // pixel
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [M_W-1:0]                  m_axis_tdata,  // peak_row, peak_col, peak_value
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lmd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lmd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import lmd_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int PB    = PIXEL_BITS;

  logic [IMG_W_BITS-1:0] image_width_q, image_width_d;
  logic [IMG_H_BITS-1:0] image_height_q, image_height_d;
  logic                  border_mode_q, border_mode_d;
  logic [COL_W-1:0]      col_q, col_d;
  logic [ROW_W-1:0]      row_q, row_d;

  logic [COL_W:0]        eff_w;
  logic [IMG_H_BITS-1:0] eff_h;
  logic [COL_W-1:0]      w_last;
  logic [ROW_W-1:0]      h_last;

  logic                  s1_valid_q, s1_valid_d;
  logic signed [PB-1:0]  s1_pixel_q;
  logic [COL_W-1:0]      s1_col_q;
  logic [ROW_W-1:0]      s1_row_q;
  pos_flags_t            s1_flags_q, flags_d;
  logic                  fwd_q;
  logic [2*PB-1:0]       fwd_data_q;

  logic                  s_fire, s1_fire, cfg_fire, out_ready;
  logic [2*PB-1:0]       mem_rd, line_rd, wr_data;

  logic [NUM_CAND-1:0]   mask;
  logic signed [PB-1:0]  cand_val [NUM_CAND];
  logic [ROW_W-1:0]      peak_row;
  logic [OUT_COL_W-1:0]  peak_col;
  logic signed [PB-1:0]  peak_value;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;

  always_comb begin
    if (image_width_q == '0) begin
      eff_w = (COL_W + 1)'(1);
    end else if (32'(image_width_q) > MAX_WIDTH) begin
      eff_w = (COL_W + 1)'(MAX_WIDTH);
    end else begin
      eff_w = (COL_W + 1)'(image_width_q);
    end
    if (image_height_q == '0) begin
      eff_h = IMG_H_BITS'(1);
    end else if (32'(image_height_q) > MAX_HEIGHT) begin
      eff_h = IMG_H_BITS'(MAX_HEIGHT);
    end else begin
      eff_h = image_height_q;
    end
    w_last = COL_W'(eff_w - (COL_W + 1)'(1));
    h_last = ROW_W'(eff_h - IMG_H_BITS'(1));
  end

  assign s1_fire       = s1_valid_q && out_ready;
  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    image_width_d  = image_width_q;
    image_height_d = image_height_q;
    border_mode_d  = border_mode_q;
    col_d          = col_q;
    row_d          = row_q;
    if (s_fire) begin
      if (col_q == w_last) begin
        col_d = '0;
        row_d = (row_q == h_last) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
    if (cfg_fire) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH: begin
          image_width_d = cfg_data_i[IMG_W_BITS-1:0];
          col_d         = '0;
          row_d         = '0;
        end
        REG_IMAGE_HEIGHT: begin
          image_height_d = cfg_data_i[IMG_H_BITS-1:0];
          col_d          = '0;
          row_d          = '0;
        end
        REG_BORDER_MODE: begin
          border_mode_d = cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    flags_d.full  = border_mode_q;
    flags_d.r1    = (row_q != '0);
    flags_d.r2    = (row_q > ROW_W'(1));
    flags_d.rlast = (row_q == h_last);
    flags_d.c1    = (col_q != '0);
    flags_d.c2    = (col_q > COL_W'(1));
    flags_d.clast = (col_q == w_last);
    s1_valid_d    = s_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= IMG_W_BITS'(5);
      image_height_q <= IMG_H_BITS'(5);
      border_mode_q  <= 1'b1;
      col_q          <= '0;
      row_q          <= '0;
      s1_valid_q     <= 1'b0;
      fwd_q          <= 1'b0;
    end else begin
      image_width_q  <= image_width_d;
      image_height_q <= image_height_d;
      border_mode_q  <= border_mode_d;
      col_q          <= col_d;
      row_q          <= row_d;
      s1_valid_q     <= s1_valid_d;
      if (s_fire) begin
        fwd_q <= s1_fire && (s1_col_q == col_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_pixel_q <= s_axis_tdata[PB-1:0];
      s1_col_q   <= col_q;
      s1_row_q   <= row_q;
      s1_flags_q <= flags_d;
      fwd_data_q <= wr_data;
    end
  end

  // A pixel in the same column as the one written back this cycle takes the
  // written word, since the memory read returns the old contents.
  assign line_rd = fwd_q ? fwd_data_q : mem_rd;
  assign wr_data = {line_rd[PB-1:0], s1_pixel_q};

  lmd_line_mem #(
    .DEPTH (MAX_WIDTH),
    .DW    (2 * PB)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (s_fire),
    .rd_addr_i (col_q),
    .rd_data_o (mem_rd),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_col_q),
    .wr_data_i (wr_data)
  );

  lmd_peak_eval #(
    .PB (PB)
  ) u_peak_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_fire),
    .top_i   (line_rd[2*PB-1:PB]),
    .mid_i   (line_rd[PB-1:0]),
    .bot_i   (s1_pixel_q),
    .flags_i (s1_flags_q),
    .mask_o  (mask),
    .value_o (cand_val)
  );

  lmd_out_seq #(
    .PB    (PB),
    .COL_W (COL_W)
  ) u_out_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (s1_fire),
    .mask_i       (mask),
    .value_i      (cand_val),
    .row_i        (s1_row_q),
    .col_i        (s1_col_q),
    .ready_o      (out_ready),
    .valid_o      (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .peak_row_o   (peak_row),
    .peak_col_o   (peak_col),
    .peak_value_o (peak_value),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = M_W'({peak_value, peak_col, peak_row});

  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= w_last)
    else $error("column counter beyond the row width");

  a_row_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= h_last)
    else $error("row counter beyond the frame height");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |-> (!m_axis_tvalid || (m_axis_tready && m_axis_tlast)))
    else $error("result register reloaded while reports are pending");

  a_group_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("report group ended without a last word");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for local_maximum_3x3_detector: pixel streams over many frame shapes,
// with a scoreboard class that predicts every peak report and checks the output words.
// Depends on lmd_pkg and the RTL under rtl/ only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lmd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 8;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    logic [15:0]          value;
    logic                 last;
  } peak_report_t;

  class peak_scoreboard;
    logic signed [15:0] row_above [MAX_WIDTH_DEF];
    logic signed [15:0] row_two_above [MAX_WIDTH_DEF];
    logic signed [15:0] win [3][3];
    int unsigned col_pos;
    int unsigned row_pos;
    logic [IMG_W_BITS-1:0] width_reg;
    logic [IMG_H_BITS-1:0] height_reg;
    logic full_mode;
    peak_report_t pending_q[$];
    int errors;
    int checked;

    function new();
      foreach (row_above[i]) begin
        row_above[i] = '0;
        row_two_above[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      col_pos = 0;
      row_pos = 0;
      width_reg = 5;
      height_reg = 5;
      full_mode = 1'b1;
      errors = 0;
      checked = 0;
    endfunction

    function int frame_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return width_reg;
    endfunction

    function int frame_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_IMAGE_WIDTH: begin
          width_reg = data[IMG_W_BITS-1:0];
          col_pos = 0;
          row_pos = 0;
        end
        REG_IMAGE_HEIGHT: begin
          height_reg = data[IMG_H_BITS-1:0];
          col_pos = 0;
          row_pos = 0;
        end
        REG_BORDER_MODE: full_mode = data[0];
        default: ;
      endcase
    endfunction

    function bit peak_at(int r, int c, int cr, int cc, int w, int h,
                         output logic signed [15:0] v);
      int wr;
      int wc;
      int nr;
      int nc;
      logic signed [15:0] centre;
      wr = r - cr + 2;
      wc = c - cc + 2;
      centre = win[wr][wc];
      v = centre;
      if (full_mode && (r < 1 || r + 2 > h || c < 1 || c + 2 > w)) return 0;
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          nr = r + dy;
          nc = c + dx;
          if (dy == 0 && dx == 0) continue;
          if (nr < 0 || nr >= h || nc < 0 || nc >= w) continue;
          if (!(win[wr + dy][wc + dx] < centre)) return 0;
        end
      end
      return 1;
    endfunction

    function void note_pixel(logic signed [15:0] px);
      int w;
      int h;
      int cr;
      int cc;
      int r;
      int c;
      int n;
      logic signed [15:0] v;
      peak_report_t found [4];
      peak_report_t rep;
      w = frame_width();
      h = frame_height();
      cr = row_pos;
      cc = col_pos;
      for (int k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2] = row_two_above[cc];
      win[1][2] = row_above[cc];
      win[2][2] = px;
      row_two_above[cc] = row_above[cc];
      row_above[cc] = px;
      n = 0;
      for (int dr = 0; dr < 2; dr++) begin
        if (dr == 0 && cr < 1) continue;
        if (dr == 1 && cr != h - 1) continue;
        for (int dc = 0; dc < 2; dc++) begin
          if (dc == 0 && cc < 1) continue;
          if (dc == 1 && cc != w - 1) continue;
          r = cr - 1 + dr;
          c = cc - 1 + dc;
          if (peak_at(r, c, cr, cc, w, h, v)) begin
            rep.row = r[ROW_W-1:0];
            rep.col = c[OUT_COL_W-1:0];
            rep.value = v;
            rep.last = 1'b0;
            found[n] = rep;
            n++;
          end
        end
      end
      for (int k = 0; k < n; k++) begin
        rep = found[k];
        rep.last = (k == n - 1);
        pending_q = {pending_q, rep};
      end
      if (cc + 1 >= w) begin
        col_pos = 0;
        row_pos = (cr + 1 >= h) ? 0 : cr + 1;
      end else begin
        col_pos = cc + 1;
      end
    endfunction

    function void check_report(logic [ROW_W-1:0] row, logic [OUT_COL_W-1:0] col,
                               logic [15:0] value, logic last);
      peak_report_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: expected no report, actual row %0d col %0d value %0d last %0b",
                 $time, row, col, $signed(value), last);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (want.row != row) begin
        $display("%0t: peak_row expected %0d actual %0d", $time, want.row, row);
        errors++;
      end
      if (want.col != col) begin
        $display("%0t: peak_col expected %0d actual %0d", $time, want.col, col);
        errors++;
      end
      if (want.value !== value) begin
        $display("%0t: peak_value expected %0d actual %0d", $time,
                 $signed(want.value), $signed(value));
        errors++;
      end
      if (want.last !== last) begin
        $display("%0t: last expected %0b actual %0b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [39:0]           m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  local_maximum_3x3_detector dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  peak_scoreboard sb;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int pixels_sent = 0;
  int reg_writes = 0;
  int phases = 0;
  int random_items = 0;

  logic signed [15:0] demo_frame [25] = '{
    -16'sd32768, 16'sd5,      16'sd5,       16'sd0,  16'sd32767,
    16'sd3,      16'sd32767,  16'sd7,       16'sd7,  -16'sd1,
    -16'sd32768, 16'sd7,      16'sd100,     16'sd7,  16'sd2,
    16'sd0,      16'sd1,      16'sd50,      16'sd50, 16'sd9,
    16'sd32767,  -16'sd32768, 16'sd2,       16'sd1,  16'sd0
  };

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_report(m_axis_tdata[11:0], m_axis_tdata[21:12], m_axis_tdata[37:22],
                      m_axis_tlast);
    end
  end

  task automatic set_idling(input idle_mode_e mode);
    sender_idle_pct = (mode == IDLE_SENDER) ? 58 : (mode == IDLE_BOTH) ? 6 : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER) ? 58 : (mode == IDLE_BOTH) ? 6 : 0;
    phases++;
  endtask

  task automatic send_pixel(input logic signed [15:0] px);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pixel(px);
    pixels_sent++;
  endtask

  function automatic logic signed [15:0] rand_pixel();
    int pick;
    int v;
    pick = $urandom_range(9);
    if (pick < 4) return 16'($urandom);
    if (pick < 8) begin
      v = $urandom_range(6);
      return 16'(v - 3);
    end
    return (pick == 8) ? 16'sd32767 : -16'sd32768;
  endfunction

  task automatic send_random(input int n, input bit counted);
    repeat (n) send_pixel(rand_pixel());
    if (counted) random_items += n;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, data);
    reg_writes++;
  endtask

  task automatic write_shape(input int w, input int h, input bit full);
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_BORDER_MODE, CFG_DATA_W'(full));
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset shape, full mode: extremes, a clear peak and tied neighbors.
    set_idling(IDLE_NONE);
    foreach (demo_frame[i]) send_pixel(demo_frame[i]);
    set_idling(IDLE_SENDER);
    send_random(40, 1'b1);

    write_reg(REG_BORDER_MODE, 13'h1FFE);
    set_idling(IDLE_RECEIVER);
    send_random(40, 1'b1);

    write_reg(REG_IMAGE_WIDTH, 13'h0000);
    write_reg(REG_IMAGE_HEIGHT, 13'h0000);
    set_idling(IDLE_BOTH);
    send_random(8, 1'b1);

    write_reg(REG_SPARE, 13'h1FFF);
    send_random(4, 1'b1);

    // Long output stall while the input keeps offering pixels.
    write_reg(REG_IMAGE_WIDTH, 13'h1803);
    write_reg(REG_IMAGE_HEIGHT, 13'h0002);
    set_idling(IDLE_NONE);
    hold_request = 400;
    send_random(40, 1'b1);

    write_shape(2, 7, 1'b1);
    set_idling(IDLE_SENDER);
    send_random(12, 1'b1);

    write_shape(7, 1, 1'b1);
    send_random(10, 1'b1);

    write_shape(1, 6, 1'b0);
    set_idling(IDLE_RECEIVER);
    send_random(12, 1'b1);

    write_shape(13'h07FF, 13'h1FFF, 1'b0);
    set_idling(IDLE_NONE);
    send_random(24, 1'b1);

    while (random_items < 240) begin
      int n;
      if ($urandom_range(3) == 0) begin
        write_reg(REG_BORDER_MODE, CFG_DATA_W'($urandom));
      end else begin
        write_shape($urandom_range(1, 8), $urandom_range(1, 6), 1'($urandom_range(1)));
      end
      set_idling(idle_mode_e'($urandom_range(3)));
      n = $urandom_range(4, 40);
      send_random(n, 1'b1);
    end

    drain();
    $display("Sent %0d pixels over %0d phases with %0d register writes; checked %0d reports.",
             pixels_sent, phases, reg_writes, sb.checked);
    $display("Shapes ranged from 1x1 frames to a clamped full-width setting, in both modes.");
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("local_maximum_3x3_detector: match");
    end else begin
      $display("local_maximum_3x3_detector: mismatch");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timeout with %0d reports still expected.", sb.outstanding());
    $display("local_maximum_3x3_detector: mismatch");
    $finish;
  end

endmodule
